FILE: rtl/core/rpal_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and rounding helper for the roll/pitch autopilot law
package rpal_pkg;

    // fixed point: angles in 1/2^ANGLE_FRAC_BITS degree
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int Q_BITS          = 16;
    localparam int ACC_W           = 40;
    localparam int OUT_W           = 12;

    // field widths
    localparam int MODE_W     = 4;
    localparam int BANK_W     = 15;
    localparam int RATE_W     = 16;
    localparam int HEADING_W  = 15;
    localparam int PITCH_W    = 14;
    localparam int LOAD_W     = 16;
    localparam int HEIGHT_W   = 20;
    localparam int CLIMB_W    = 16;
    localparam int STICK_W    = 16;
    localparam int MODE_OUT_W = 2;

    // register widths
    localparam int ALT_W       = 19;
    localparam int CLIMB_TGT_W = 10;
    localparam int CAPTURE_W   = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 19;

    // stored targets
    localparam int TGT_W = 16;

    // shared multiplier: unsigned gain times signed operand
    localparam int KW     = 16;
    localparam int MUL_W  = 17;
    localparam int PROD_W = KW + 1 + MUL_W;

    // Q16 gains
    localparam logic [KW-1:0] K_ROLL_RATE = 16'd39322;
    localparam logic [KW-1:0] K_ROLL      = 16'd6554;
    localparam logic [KW-1:0] K_HDG_ERR   = 16'd58982;
    localparam logic [KW-1:0] K_STICK     = KW'(10 << (ANGLE_FRAC_BITS + 2));

    localparam int ROUND_HALF       = 1 << (Q_BITS - 1);
    localparam int AIL_LIM          = 30 << ANGLE_FRAC_BITS;
    localparam int ELV_LIM          = 20 << ANGLE_FRAC_BITS;
    localparam int LOAD_1G          = 2048;
    localparam int ALT_ERR_LO       = -30 * 8;
    localparam int ALT_ERR_HI       = 20 * 8;
    localparam int CLIMB_LIM        = 256;
    localparam int PITCH_OFFSET_Q16 = 172360;
    localparam int VS_REF_LIM       = 10 << (ANGLE_FRAC_BITS + Q_BITS);

    // mode enable bits
    localparam int EN_ROLL  = 0;
    localparam int EN_PITCH = 1;
    localparam int EN_ALT   = 2;
    localparam int EN_VS    = 3;

    // register reset values
    localparam logic [HEADING_W-1:0]          HEADING_RST = 15'd4480;
    localparam logic [ALT_W-1:0]              ALT_RST     = 19'd3200;
    localparam logic signed [CLIMB_TGT_W-1:0] CLIMB_RST   = 10'sd128;
    localparam logic [CAPTURE_W-1:0]          CAPTURE_RST = 12'd448;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADING  = 2'd0,
        CFG_ALTITUDE = 2'd1,
        CFG_CLIMB    = 2'd2,
        CFG_CAPTURE  = 2'd3
    } cfg_reg_t;

    typedef enum logic [MODE_OUT_W-1:0] {
        ROLL_MANUAL  = 2'd0,
        ROLL_HOLD    = 2'd1,
        ROLL_HEADING = 2'd2
    } roll_mode_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_DAMP,
        CS_ROLL,
        CS_HEAD,
        CS_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic damp;
        logic roll;
        logic head;
        logic commit;
    } rpal_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } rpal_stat_t;

    // Q16 value to angle units, round half up, saturate at +-lim
    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] v,
        input int                       lim
    );
        logic signed [ACC_W-1:0]        r;
        logic signed [ACC_W-Q_BITS-1:0] q;
        logic signed [ACC_W-Q_BITS-1:0] hi;
        logic signed [ACC_W-Q_BITS-1:0] lo;
        logic signed [ACC_W-Q_BITS-1:0] res;
        r  = v + ACC_W'(ROUND_HALF);
        q  = r[ACC_W-1:Q_BITS];
        hi = (ACC_W - Q_BITS)'(lim);
        lo = -hi;
        if (q > hi)
        begin
            res = hi;
        end
        else if (q < lo)
        begin
            res = lo;
        end
        else
        begin
            res = q;
        end
        return res[OUT_W-1:0];
    endfunction

endpackage

FILE: rtl/core/rpal_in_if.sv
`timescale 1ns / 1ps
// input channel: one control frame of sensor, stick and mode data
interface rpal_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [rpal_pkg::MODE_W-1:0]              mode_enables;
    logic signed [rpal_pkg::BANK_W-1:0]       bank_angle;
    logic signed [rpal_pkg::RATE_W-1:0]       bank_rate;
    logic [rpal_pkg::HEADING_W-1:0]           heading_now;
    logic signed [rpal_pkg::PITCH_W-1:0]      pitch_angle;
    logic signed [rpal_pkg::RATE_W-1:0]       pitch_rate;
    logic signed [rpal_pkg::LOAD_W-1:0]       normal_load;
    logic signed [rpal_pkg::HEIGHT_W-1:0]     height_now;
    logic signed [rpal_pkg::CLIMB_W-1:0]      climb_rate_now;
    logic signed [rpal_pkg::STICK_W-1:0]      stick_roll;
    logic signed [rpal_pkg::STICK_W-1:0]      stick_pitch;

    modport source (
        output valid, mode_enables, bank_angle, bank_rate, heading_now, pitch_angle,
               pitch_rate, normal_load, height_now, climb_rate_now, stick_roll, stick_pitch,
        input  ready
    );

    modport sink (
        input  valid, mode_enables, bank_angle, bank_rate, heading_now, pitch_angle,
               pitch_rate, normal_load, height_now, climb_rate_now, stick_roll, stick_pitch,
        output ready
    );
endinterface

FILE: rtl/core/rpal_out_if.sv
`timescale 1ns / 1ps
// output channel: surface commands and active roll mode
interface rpal_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rpal_pkg::OUT_W-1:0]      aileron_plus;
    logic signed [rpal_pkg::OUT_W-1:0]      aileron_minus;
    logic signed [rpal_pkg::OUT_W-1:0]      elevator_cmd;
    logic [rpal_pkg::MODE_OUT_W-1:0]        roll_mode_now;

    modport source (
        output valid, aileron_plus, aileron_minus, elevator_cmd, roll_mode_now,
        input  ready
    );

    modport sink (
        input  valid, aileron_plus, aileron_minus, elevator_cmd, roll_mode_now,
        output ready
    );
endinterface

FILE: rtl/core/rpal_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine for the autopilot law datapath
module rpal_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rpal_pkg::rpal_stat_t   stat,
    output rpal_pkg::rpal_cmd_t    cmd
);

    rpal_pkg::ctrl_state_t state_reg;
    rpal_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpal_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpal_pkg::CS_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = rpal_pkg::CS_DAMP;
                end
            end
            rpal_pkg::CS_DAMP: state_next = rpal_pkg::CS_ROLL;
            rpal_pkg::CS_ROLL: state_next = rpal_pkg::CS_HEAD;
            rpal_pkg::CS_HEAD: state_next = rpal_pkg::CS_DONE;
            rpal_pkg::CS_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = rpal_pkg::CS_IDLE;
                end
            end
            default: state_next = rpal_pkg::CS_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            rpal_pkg::CS_IDLE: cmd.take   = 1'b1;
            rpal_pkg::CS_DAMP: cmd.damp   = 1'b1;
            rpal_pkg::CS_ROLL: cmd.roll   = 1'b1;
            rpal_pkg::CS_HEAD: cmd.head   = 1'b1;
            rpal_pkg::CS_DONE: cmd.commit = stat.out_free;
            default:           cmd        = '0;
        endcase
    end

endmodule

FILE: rtl/core/rpal_datapath.sv
`timescale 1ns / 1ps
// datapath: config registers, law state, shared multiplier, pitch terms, output register
module rpal_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rpal_pkg::rpal_cmd_t                  cmd,
    output rpal_pkg::rpal_stat_t                 stat,
    input  logic                                 cfg_write,
    input  logic [rpal_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpal_pkg::CFG_DATA_W-1:0]      cfg_data,
    rpal_in_if.sink                              frame,
    rpal_out_if.source                           surfaces
);

    localparam int F = rpal_pkg::ANGLE_FRAC_BITS;
    localparam int A = rpal_pkg::ACC_W;

    // configuration
    logic [rpal_pkg::HEADING_W-1:0]          heading_target_reg;
    logic [rpal_pkg::ALT_W-1:0]              altitude_target_reg;
    logic signed [rpal_pkg::CLIMB_TGT_W-1:0] climb_rate_target_reg;
    logic [rpal_pkg::CAPTURE_W-1:0]          capture_band_reg;

    // captured transaction
    logic [rpal_pkg::MODE_W-1:0]             mode_en_reg;
    logic signed [rpal_pkg::BANK_W-1:0]      bank_angle_reg;
    logic signed [rpal_pkg::RATE_W-1:0]      bank_rate_reg;
    logic [rpal_pkg::HEADING_W-1:0]          heading_now_reg;
    logic signed [rpal_pkg::PITCH_W-1:0]     pitch_angle_reg;
    logic signed [rpal_pkg::RATE_W-1:0]      pitch_rate_reg;
    logic signed [rpal_pkg::LOAD_W-1:0]      normal_load_reg;
    logic signed [rpal_pkg::HEIGHT_W-1:0]    height_now_reg;
    logic signed [rpal_pkg::CLIMB_W-1:0]     climb_rate_now_reg;
    logic signed [rpal_pkg::STICK_W-1:0]     stick_roll_reg;
    logic signed [rpal_pkg::STICK_W-1:0]     stick_pitch_reg;

    // law state
    rpal_pkg::roll_mode_t                    roll_mode_reg;
    logic                                    engaged_reg;
    logic signed [rpal_pkg::TGT_W-1:0]       bank_target_reg;
    logic signed [rpal_pkg::TGT_W-1:0]       pitch_target_reg;
    logic signed [rpal_pkg::TGT_W-1:0]       previous_bank_reg;

    // work registers
    logic signed [rpal_pkg::PROD_W-1:0]      prod_reg;
    logic signed [rpal_pkg::PROD_W-1:0]      damp_reg;
    logic signed [A-1:0]                     term_reg;
    logic signed [A-1:0]                     el_sum_reg;
    logic signed [rpal_pkg::OUT_W-1:0]       ap_reg;
    logic signed [rpal_pkg::OUT_W-1:0]       am_reg;
    logic signed [rpal_pkg::OUT_W-1:0]       el_reg;

    // output stage
    logic                                    out_valid_reg;
    logic signed [rpal_pkg::OUT_W-1:0]       aileron_plus_reg;
    logic signed [rpal_pkg::OUT_W-1:0]       aileron_minus_reg;
    logic signed [rpal_pkg::OUT_W-1:0]       elevator_cmd_reg;
    rpal_pkg::roll_mode_t                    roll_mode_out_reg;

    // combinational
    logic                                    load;
    rpal_pkg::roll_mode_t                    mode_new;
    logic signed [rpal_pkg::TGT_W:0]         prev_w;
    logic signed [rpal_pkg::TGT_W:0]         prev_mag;
    logic [rpal_pkg::KW-1:0]                 mul_k;
    logic signed [rpal_pkg::MUL_W-1:0]       mul_op;
    logic signed [rpal_pkg::PROD_W-1:0]      prod;
    logic signed [A-1:0]                     pitch_q;
    logic signed [A-1:0]                     sp_w;
    logic signed [A-1:0]                     ld_w;
    logic signed [A-1:0]                     t_man;
    logic signed [A-1:0]                     hd_w;
    logic signed [A-1:0]                     t_hold;
    logic signed [A-1:0]                     ad_w;
    logic signed [A-1:0]                     adc_w;
    logic signed [A-1:0]                     t_alt;
    logic signed [A-1:0]                     vref_w;
    logic signed [A-1:0]                     vd_w;
    logic signed [A-1:0]                     pref_vs;
    logic signed [A-1:0]                     t_vs;
    logic signed [A-1:0]                     term_sel;
    logic signed [rpal_pkg::OUT_W-1:0]       head_sat;

    assign load        = cmd.take & frame.valid;
    assign frame.ready = cmd.take;

    assign stat.in_valid = frame.valid;
    assign stat.out_free = !out_valid_reg || surfaces.ready;

    assign surfaces.valid         = out_valid_reg;
    assign surfaces.aileron_plus  = aileron_plus_reg;
    assign surfaces.aileron_minus = aileron_minus_reg;
    assign surfaces.elevator_cmd  = elevator_cmd_reg;
    assign surfaces.roll_mode_now = roll_mode_out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_target_reg    <= rpal_pkg::HEADING_RST;
            altitude_target_reg   <= rpal_pkg::ALT_RST;
            climb_rate_target_reg <= rpal_pkg::CLIMB_RST;
            capture_band_reg      <= rpal_pkg::CAPTURE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rpal_pkg::CFG_HEADING:
                    heading_target_reg <= cfg_data[rpal_pkg::HEADING_W-1:0];
                rpal_pkg::CFG_ALTITUDE:
                    altitude_target_reg <= cfg_data[rpal_pkg::ALT_W-1:0];
                rpal_pkg::CFG_CLIMB:
                    climb_rate_target_reg <= cfg_data[rpal_pkg::CLIMB_TGT_W-1:0];
                rpal_pkg::CFG_CAPTURE:
                    capture_band_reg <= cfg_data[rpal_pkg::CAPTURE_W-1:0];
                default:
                    capture_band_reg <= capture_band_reg;
            endcase
        end
    end

    // capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_en_reg        <= frame.mode_enables;
            bank_angle_reg     <= frame.bank_angle;
            bank_rate_reg      <= frame.bank_rate;
            heading_now_reg    <= frame.heading_now;
            pitch_angle_reg    <= frame.pitch_angle;
            pitch_rate_reg     <= frame.pitch_rate;
            normal_load_reg    <= frame.normal_load;
            height_now_reg     <= frame.height_now;
            climb_rate_now_reg <= frame.climb_rate_now;
            stick_roll_reg     <= frame.stick_roll;
            stick_pitch_reg    <= frame.stick_pitch;
        end
    end

    // roll mode for this frame
    always_comb
    begin
        prev_w   = (rpal_pkg::TGT_W + 1)'(previous_bank_reg);
        prev_mag = (prev_w < 0) ? -prev_w : prev_w;
        if (mode_en_reg[rpal_pkg::EN_ROLL])
        begin
            if (!engaged_reg)
            begin
                mode_new = (prev_mag < $signed((rpal_pkg::TGT_W + 1)'(capture_band_reg)))
                           ? rpal_pkg::ROLL_HEADING : rpal_pkg::ROLL_HOLD;
            end
            else
            begin
                mode_new = roll_mode_reg;
            end
        end
        else
        begin
            mode_new = rpal_pkg::ROLL_MANUAL;
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_k  = rpal_pkg::K_ROLL_RATE;
        mul_op = rpal_pkg::MUL_W'(bank_rate_reg);
        if (cmd.roll)
        begin
            if (mode_new == rpal_pkg::ROLL_MANUAL)
            begin
                mul_k  = rpal_pkg::K_STICK;
                mul_op = rpal_pkg::MUL_W'(stick_roll_reg);
            end
            else
            begin
                mul_k  = rpal_pkg::K_ROLL;
                mul_op = rpal_pkg::MUL_W'(bank_target_reg) - rpal_pkg::MUL_W'(bank_angle_reg);
            end
        end
        else if (cmd.head)
        begin
            mul_k  = rpal_pkg::K_HDG_ERR;
            mul_op = rpal_pkg::MUL_W'(heading_target_reg) - rpal_pkg::MUL_W'(heading_now_reg);
        end
    end

    assign prod = $signed({1'b0, mul_k}) * mul_op;

    // pitch law terms in Q16 angle units, by shift and add
    always_comb
    begin
        pitch_q = A'(pitch_angle_reg) <<< (rpal_pkg::Q_BITS + 2);

        // manual: -10 deg * stick + 3 deg/g * (load - 1g)
        sp_w  = A'(stick_pitch_reg);
        ld_w  = A'(normal_load_reg) - A'(rpal_pkg::LOAD_1G);
        t_man = ((ld_w <<< (F + 6)) + (ld_w <<< (F + 5)))
              - ((sp_w <<< (F + 5)) + (sp_w <<< (F + 3)));

        // pitch hold: -10 * (target - pitch)
        hd_w   = A'(pitch_target_reg) - A'(pitch_angle_reg);
        t_hold = -((hd_w <<< (rpal_pkg::Q_BITS + 3)) + (hd_w <<< (rpal_pkg::Q_BITS + 1)));

        // altitude hold: clamp in height units, then scale to the reference
        ad_w = $signed(A'(altitude_target_reg)) - A'(height_now_reg);
        if (ad_w > A'(rpal_pkg::ALT_ERR_HI))
        begin
            adc_w = A'(rpal_pkg::ALT_ERR_HI);
        end
        else if (ad_w < A'(rpal_pkg::ALT_ERR_LO))
        begin
            adc_w = A'(rpal_pkg::ALT_ERR_LO);
        end
        else
        begin
            adc_w = ad_w;
        end
        t_alt = pitch_q - (adc_w <<< (F + 15));

        // vertical speed hold: 40 deg per m/s plus pitch offset, clamped
        vref_w = A'(climb_rate_target_reg);
        if (vref_w > A'(rpal_pkg::CLIMB_LIM))
        begin
            vref_w = A'(rpal_pkg::CLIMB_LIM);
        end
        else if (vref_w < -A'(rpal_pkg::CLIMB_LIM))
        begin
            vref_w = -A'(rpal_pkg::CLIMB_LIM);
        end
        vd_w    = vref_w - A'(climb_rate_now_reg);
        pref_vs = (vd_w <<< (F + 15)) + (vd_w <<< (F + 13))
                + (A'(rpal_pkg::PITCH_OFFSET_Q16) <<< F);
        if (pref_vs > A'(rpal_pkg::VS_REF_LIM))
        begin
            pref_vs = A'(rpal_pkg::VS_REF_LIM);
        end
        else if (pref_vs < -A'(rpal_pkg::VS_REF_LIM))
        begin
            pref_vs = -A'(rpal_pkg::VS_REF_LIM);
        end
        t_vs = pitch_q - (pref_vs <<< 2);

        // later modes win
        priority if (mode_en_reg[rpal_pkg::EN_VS])
        begin
            term_sel = t_vs;
        end
        else if (mode_en_reg[rpal_pkg::EN_ALT])
        begin
            term_sel = t_alt;
        end
        else if (mode_en_reg[rpal_pkg::EN_PITCH])
        begin
            term_sel = t_hold;
        end
        else
        begin
            term_sel = t_man;
        end
    end

    assign head_sat = rpal_pkg::round_sat(A'(prod_reg), rpal_pkg::AIL_LIM);

    // work pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.damp || cmd.roll || cmd.head)
        begin
            prod_reg <= prod;
        end
        if (cmd.damp)
        begin
            term_reg <= term_sel;
        end
        if (cmd.roll)
        begin
            damp_reg   <= prod_reg;
            el_sum_reg <= term_reg + (A'(pitch_rate_reg) <<< (rpal_pkg::Q_BITS - 1));
        end
        if (cmd.head)
        begin
            ap_reg <= rpal_pkg::round_sat(A'(prod_reg) + A'(damp_reg), rpal_pkg::AIL_LIM);
            am_reg <= rpal_pkg::round_sat(A'(damp_reg) - A'(prod_reg), rpal_pkg::AIL_LIM);
            el_reg <= rpal_pkg::round_sat(el_sum_reg, rpal_pkg::ELV_LIM);
        end
    end

    // law state update at commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_mode_reg     <= rpal_pkg::ROLL_MANUAL;
            engaged_reg       <= 1'b0;
            bank_target_reg   <= '0;
            pitch_target_reg  <= '0;
            previous_bank_reg <= '0;
        end
        else if (cmd.commit)
        begin
            roll_mode_reg     <= mode_new;
            engaged_reg       <= mode_en_reg[rpal_pkg::EN_ROLL];
            previous_bank_reg <= rpal_pkg::TGT_W'(bank_angle_reg);
            unique case (mode_new)
                rpal_pkg::ROLL_MANUAL:  bank_target_reg <= rpal_pkg::TGT_W'(bank_angle_reg);
                rpal_pkg::ROLL_HEADING: bank_target_reg <= rpal_pkg::TGT_W'(head_sat);
                rpal_pkg::ROLL_HOLD:    bank_target_reg <= bank_target_reg;
                default:                bank_target_reg <= bank_target_reg;
            endcase
            if (!mode_en_reg[rpal_pkg::EN_PITCH])
            begin
                pitch_target_reg <= rpal_pkg::TGT_W'(pitch_angle_reg);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (surfaces.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            aileron_plus_reg  <= ap_reg;
            aileron_minus_reg <= am_reg;
            elevator_cmd_reg  <= el_reg;
            roll_mode_out_reg <= mode_new;
        end
    end

endmodule

FILE: rtl/core/roll_pitch_autopilot_law_unit.sv
`timescale 1ns / 1ps
// top level of the roll and pitch autopilot control law
//
// usage
//   frame: one control frame per transaction (attitude, rates, load factor,
//     height, vertical speed, sticks, mode enables); taken when valid and ready
//   surfaces: one result per frame (two aileron commands, elevator command,
//     active roll mode); taken when valid and ready
//   cfg_write / cfg_index / cfg_data: register writes (heading, altitude,
//     climb rate targets and the heading capture band), only while idle
// timing
//   a frame is taken in the idle cycle, then the work steps in order: rate damping
//   product, roll term product, heading product, commit; the result is
//   valid in the cycle after commit
//   a new frame is taken only after the previous frame has committed; the damping,
//   roll and heading steps share the single 17x17 gain multiplier
// reset
//   roll mode manual, bank and pitch targets and latches zero, registers at defaults
// stall
//   a finished result waits in the output register; the next frame is taken
//   and worked meanwhile, and its commit holds until the register is free
module roll_pitch_autopilot_law_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [rpal_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpal_pkg::CFG_DATA_W-1:0]      cfg_data,
    rpal_in_if.sink                              frame,
    rpal_out_if.source                           surfaces
);

    // controller to datapath commands and datapath status
    rpal_pkg::rpal_cmd_t  cmd_w;
    rpal_pkg::rpal_stat_t stat_w;

    // sequencer: idle, damp, roll, head, done
    rpal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat_w),
        .cmd   (cmd_w)
    );

    // arithmetic, law state and output register
    rpal_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_w),
        .stat      (stat_w),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame),
        .surfaces  (surfaces)
    );

    // one frame in flight: no transaction right after an accepted one
    a_single_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready) |=> !frame.ready)
        else $error("frame taken while previous frame still in work");

    // a commit never overwrites an untaken result
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (surfaces.valid && !surfaces.ready) |-> !cmd_w.commit)
        else $error("result overwritten while stalled");

    // elevator command stays within its saturation limit
    a_elevator_sat: assert property (@(posedge clk) disable iff (!rst_n)
        surfaces.valid |-> (surfaces.elevator_cmd <= rpal_pkg::OUT_W'(rpal_pkg::ELV_LIM)
                         && surfaces.elevator_cmd >= -rpal_pkg::OUT_W'(rpal_pkg::ELV_LIM)))
        else $error("elevator command out of range");

    // aileron commands stay within their saturation limit
    a_aileron_sat: assert property (@(posedge clk) disable iff (!rst_n)
        surfaces.valid |-> (surfaces.aileron_plus <= rpal_pkg::OUT_W'(rpal_pkg::AIL_LIM)
                         && surfaces.aileron_plus >= -rpal_pkg::OUT_W'(rpal_pkg::AIL_LIM)
                         && surfaces.aileron_minus <= rpal_pkg::OUT_W'(rpal_pkg::AIL_LIM)
                         && surfaces.aileron_minus >= -rpal_pkg::OUT_W'(rpal_pkg::AIL_LIM)))
        else $error("aileron command out of range");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the roll and pitch autopilot control law unit
module tb_top;
    import rpal_pkg::*;

    // run shape
    localparam int CYCLE_LIMIT     = 100000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES   = 20;

    // mode enable words
    localparam logic [MODE_W-1:0] M_NONE  = '0;
    localparam logic [MODE_W-1:0] M_ROLL  = MODE_W'(1 << EN_ROLL);
    localparam logic [MODE_W-1:0] M_PITCH = MODE_W'(1 << EN_PITCH);
    localparam logic [MODE_W-1:0] M_ALT   = MODE_W'(1 << EN_ALT);
    localparam logic [MODE_W-1:0] M_VS    = MODE_W'(1 << EN_VS);

    // directed rows: expected value typed in, or taken from the law predictor
    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    // law constants, scaled values carry 16 extra fraction bits over angle units
    localparam longint DEG_SCALED     = longint'(1) << 22;
    localparam longint STICK_SCALE    = 10 * 256;
    localparam longint GAIN_ROLL_RATE = 39322;
    localparam longint GAIN_ROLL      = 6554;
    localparam longint GAIN_HEADING   = 58982;
    localparam longint GAIN_HALF      = 32768;
    localparam longint PITCH_OFFSET   = 172360 * 64;
    localparam longint ONE_G          = 2048;
    localparam longint AIL_MAX        = 1920;
    localparam longint ELV_MAX        = 1280;

    typedef struct {
        logic [MODE_W-1:0]           mode_enables;
        logic signed [BANK_W-1:0]    bank_angle;
        logic signed [RATE_W-1:0]    bank_rate;
        logic [HEADING_W-1:0]        heading_now;
        logic signed [PITCH_W-1:0]   pitch_angle;
        logic signed [RATE_W-1:0]    pitch_rate;
        logic signed [LOAD_W-1:0]    normal_load;
        logic signed [HEIGHT_W-1:0]  height_now;
        logic signed [CLIMB_W-1:0]   climb_rate_now;
        logic signed [STICK_W-1:0]   stick_roll;
        logic signed [STICK_W-1:0]   stick_pitch;
    } frame_t;

    typedef struct {
        logic signed [OUT_W-1:0] ail_plus;
        logic signed [OUT_W-1:0] ail_minus;
        logic signed [OUT_W-1:0] elev;
        roll_mode_t              roll_mode;
    } surf_t;

    typedef struct {
        frame_t f;
        bit     typed;
        surf_t  want;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    cfg_reg_t               cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rpal_in_if  frame_ch ();
    rpal_out_if surf_ch ();

    roll_pitch_autopilot_law_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame_ch),
        .surfaces  (surf_ch)
    );

    // predictor copy of the registers, values after reset
    logic [HEADING_W-1:0]           tgt_heading  = 15'd4480;
    logic [ALT_W-1:0]               tgt_altitude = 19'd3200;
    logic signed [CLIMB_TGT_W-1:0]  tgt_climb    = 10'sd128;
    logic [CAPTURE_W-1:0]           capture_lim  = 12'd448;

    // predictor copy of the law state
    roll_mode_t law_roll_mode = ROLL_MANUAL;
    bit         law_engaged   = 1'b0;
    longint     law_bank_ref  = 0;
    longint     law_pitch_ref = 0;
    longint     law_last_bank = 0;

    surf_t      pending_surfaces[$];
    dir_row_t   dir_rows[$];
    logic [MODE_W-1:0] mode_word = '0;
    bit         idle_on = 1'b1;
    int         fail_count = 0;
    int         frames_sent = 0;
    int         surfaces_checked = 0;
    int         cycle_count = 0;
    int         mode_hits[3] = '{0, 0, 0};

    // reference values for the first phases of the random part
    logic [CFG_DATA_W-1:0] phase_cfg [6][4] = '{
        '{19'd4480,  19'd3200,   19'd128,   19'd448},   // reset values
        '{19'd0,     19'd0,      19'd0,     19'd0},     // all at floor
        '{19'h7FFFF, 19'h7FFFF,  19'h7FFFF, 19'h7FFFF}, // all bits set, climb reads -1
        '{19'd23040, 19'd524287, 19'h300,   19'd2880},  // in-range extremes, climb -256
        '{19'd0,     19'd0,      19'h1FF,   19'd2880},  // climb 511, clamps to +256
        '{19'd23040, 19'd524287, 19'h200,   19'd0}      // climb -512, no capture band
    };

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog, ends a hung run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // scaled value to angle units: round half up, then saturate
    function automatic logic signed [OUT_W-1:0] to_units(longint scaled, longint lim);
        longint u;
        u = (scaled + 32768) >>> 16;
        if (u > lim)
            u = lim;
        else if (u < -lim)
            u = -lim;
        return OUT_W'(u);
    endfunction

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // one control frame through the law, updates the predictor state
    function automatic surf_t autopilot_law(frame_t f);
        longint bank, brate, head, pitch, prate, load, height, climb, sroll, spitch;
        longint damp, roll_term, el, pref, vref, prev_mag;
        surf_t  r;
        bank   = longint'(f.bank_angle);
        brate  = longint'(f.bank_rate);
        head   = longint'(f.heading_now);
        pitch  = longint'(f.pitch_angle);
        prate  = longint'(f.pitch_rate);
        load   = longint'(f.normal_load);
        height = longint'(f.height_now);
        climb  = longint'(f.climb_rate_now);
        sroll  = longint'(f.stick_roll);
        spitch = longint'(f.stick_pitch);

        // engage: capture band decides on the bank seen in the frame before
        if (f.mode_enables[EN_ROLL])
        begin
            if (!law_engaged)
            begin
                prev_mag = (law_last_bank < 0) ? -law_last_bank : law_last_bank;
                law_roll_mode = (prev_mag < longint'(capture_lim)) ? ROLL_HEADING : ROLL_HOLD;
            end
            law_engaged = 1'b1;
        end
        else
        begin
            law_engaged   = 1'b0;
            law_roll_mode = ROLL_MANUAL;
        end

        damp = GAIN_ROLL_RATE * brate;
        if (law_roll_mode == ROLL_MANUAL)
            roll_term = STICK_SCALE * sroll;
        else
            roll_term = GAIN_ROLL * (law_bank_ref - bank);
        r.ail_plus  = to_units(roll_term + damp, AIL_MAX);
        r.ail_minus = to_units(damp - roll_term, AIL_MAX);

        // bank reference: tracks bank in manual, one frame behind heading error in heading hold
        if (law_roll_mode == ROLL_MANUAL)
            law_bank_ref = bank;
        else if (law_roll_mode == ROLL_HEADING)
            law_bank_ref = to_units(GAIN_HEADING * (longint'(tgt_heading) - head), AIL_MAX);

        if (f.mode_enables[EN_PITCH])
            el = -10 * (law_pitch_ref - pitch) * 65536 + GAIN_HALF * prate;
        else
        begin
            el = -STICK_SCALE * spitch + GAIN_HALF * prate + 3 * (load - ONE_G) * 2048;
            law_pitch_ref = pitch;
        end
        if (f.mode_enables[EN_ALT])
        begin
            pref = clamp_to((longint'(tgt_altitude) - height) * 524288,
                            -30 * DEG_SCALED, 20 * DEG_SCALED);
            el = -4 * (pref - pitch * 65536) + GAIN_HALF * prate;
        end
        if (f.mode_enables[EN_VS])
        begin
            vref = clamp_to(longint'(tgt_climb), -256, 256);
            pref = clamp_to(40 * (vref - climb) * 65536 + PITCH_OFFSET,
                            -10 * DEG_SCALED, 10 * DEG_SCALED);
            el = -4 * (pref - pitch * 65536) + GAIN_HALF * prate;
        end
        r.elev = to_units(el, ELV_MAX);

        law_last_bank = bank;
        r.roll_mode   = law_roll_mode;
        mode_hits[int'(law_roll_mode)]++;
        return r;
    endfunction

    function automatic frame_t frame_of(logic [MODE_W-1:0] modes, longint bank, longint brate,
                                        longint head, longint pitch, longint prate,
                                        longint load, longint height, longint climb,
                                        longint sroll, longint spitch);
        frame_t f;
        f.mode_enables   = modes;
        f.bank_angle     = BANK_W'(bank);
        f.bank_rate      = RATE_W'(brate);
        f.heading_now    = HEADING_W'(head);
        f.pitch_angle    = PITCH_W'(pitch);
        f.pitch_rate     = RATE_W'(prate);
        f.normal_load    = LOAD_W'(load);
        f.height_now     = HEIGHT_W'(height);
        f.climb_rate_now = CLIMB_W'(climb);
        f.stick_roll     = STICK_W'(sroll);
        f.stick_pitch    = STICK_W'(spitch);
        return f;
    endfunction

    task automatic row(frame_t f, bit typed, logic signed [OUT_W-1:0] ap,
                       logic signed [OUT_W-1:0] am, logic signed [OUT_W-1:0] el,
                       roll_mode_t rm);
        dir_row_t d;
        d.f              = f;
        d.typed          = typed;
        d.want.ail_plus  = ap;
        d.want.ail_minus = am;
        d.want.elev      = el;
        d.want.roll_mode = rm;
        dir_rows.push_back(d);
    endtask

    // mostly values near the operating point, some field extremes, some raw bits
    function automatic longint draw(longint lo, longint hi, longint centre, longint spread);
        int unsigned sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0: return lo;
            1: return hi;
            2: return longint'($urandom);
            3, 4, 5: return lo + longint'($urandom_range(0, int'(hi - lo)));
            default: return centre - spread + longint'($urandom_range(0, int'(2 * spread)));
        endcase
    endfunction

    function automatic frame_t random_frame();
        // mode word is held over runs of frames so the hold modes settle in
        if ($urandom_range(0, 5) == 0)
            mode_word = MODE_W'($urandom_range(0, 15));
        return frame_of(mode_word,
                        draw(-11520, 11520, 0, longint'(capture_lim) + 64),
                        draw(-32768, 32767, 0, 3000),
                        draw(0, 23040, longint'(tgt_heading), 2400),
                        draw(-5760, 5760, 0, 1500),
                        draw(-32768, 32767, 0, 2000),
                        draw(-32768, 32767, ONE_G, 1500),
                        draw(-524288, 524287, longint'(tgt_altitude), 200),
                        draw(-32768, 32767, clamp_to(longint'(tgt_climb), -256, 256), 24),
                        draw(-16384, 16384, 0, 4000),
                        draw(-16384, 16384, 0, 4000));
    endfunction

    // one frame transaction, with an optional gap ahead of it
    task automatic send_frame(frame_t f, bit typed, surf_t want);
        surf_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        frame_ch.valid          <= 1'b1;
        frame_ch.mode_enables   <= f.mode_enables;
        frame_ch.bank_angle     <= f.bank_angle;
        frame_ch.bank_rate      <= f.bank_rate;
        frame_ch.heading_now    <= f.heading_now;
        frame_ch.pitch_angle    <= f.pitch_angle;
        frame_ch.pitch_rate     <= f.pitch_rate;
        frame_ch.normal_load    <= f.normal_load;
        frame_ch.height_now     <= f.height_now;
        frame_ch.climb_rate_now <= f.climb_rate_now;
        frame_ch.stick_roll     <= f.stick_roll;
        frame_ch.stick_pitch    <= f.stick_pitch;
        do
            @(posedge clk);
        while (!frame_ch.ready);
        // predictor always runs so its state follows typed rows too
        predicted = autopilot_law(f);
        pending_surfaces.push_back(typed ? want : predicted);
        frames_sent++;
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain();
        frame_ch.valid <= 1'b0;
        while (pending_surfaces.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_HEADING:  tgt_heading  = HEADING_W'(data);
            CFG_ALTITUDE: tgt_altitude = ALT_W'(data);
            CFG_CLIMB:    tgt_climb    = CLIMB_TGT_W'(data);
            CFG_CAPTURE:  capture_lim  = CAPTURE_W'(data);
            default: ;
        endcase
    endtask

    task automatic program_targets(logic [CFG_DATA_W-1:0] hd, logic [CFG_DATA_W-1:0] alt,
                                   logic [CFG_DATA_W-1:0] clb, logic [CFG_DATA_W-1:0] cap);
        write_reg(CFG_HEADING, hd);
        write_reg(CFG_ALTITUDE, alt);
        write_reg(CFG_CLIMB, clb);
        write_reg(CFG_CAPTURE, cap);
        cfg_write <= 1'b0;
    endtask

    // result side: random back-pressure, every surfaces transaction checked in order
    initial
    begin : surfaces_monitor
        surf_t want;
        int    stall_left;
        stall_left = 0;
        surf_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (surf_ch.valid && surf_ch.ready)
            begin
                if (pending_surfaces.size() == 0)
                begin
                    $error("surfaces transaction with no frame outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_surfaces.pop_front();
                    surfaces_checked++;
                    if (surf_ch.aileron_plus !== want.ail_plus)
                    begin
                        $error("aileron_plus: expected %0d, got %0d",
                               want.ail_plus, surf_ch.aileron_plus);
                        fail_count++;
                    end
                    if (surf_ch.aileron_minus !== want.ail_minus)
                    begin
                        $error("aileron_minus: expected %0d, got %0d",
                               want.ail_minus, surf_ch.aileron_minus);
                        fail_count++;
                    end
                    if (surf_ch.elevator_cmd !== want.elev)
                    begin
                        $error("elevator_cmd: expected %0d, got %0d",
                               want.elev, surf_ch.elevator_cmd);
                        fail_count++;
                    end
                    if (surf_ch.roll_mode_now !== want.roll_mode)
                    begin
                        $error("roll_mode_now: expected %0d, got %0d",
                               want.roll_mode, surf_ch.roll_mode_now);
                        fail_count++;
                    end
                end
            end
            // random stall bursts while idling is on
            if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                surf_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                surf_ch.ready <= 1'b1;
        end
    end

    // stimulus: directed table, then random phases under several register settings
    initial
    begin : stimulus
        surf_t none;
        int    p;
        none = '{ail_plus: '0, ail_minus: '0, elev: '0, roll_mode: ROLL_MANUAL};

        rst_n                   <= 1'b0;
        cfg_write               <= 1'b0;
        cfg_index               <= CFG_HEADING;
        cfg_data                <= '0;
        frame_ch.valid          <= 1'b0;
        frame_ch.mode_enables   <= '0;
        frame_ch.bank_angle     <= '0;
        frame_ch.bank_rate      <= '0;
        frame_ch.heading_now    <= '0;
        frame_ch.pitch_angle    <= '0;
        frame_ch.pitch_rate     <= '0;
        frame_ch.normal_load    <= '0;
        frame_ch.height_now     <= '0;
        frame_ch.climb_rate_now <= '0;
        frame_ch.stick_roll     <= '0;
        frame_ch.stick_pitch    <= '0;

        // directed table, registers at reset values
        // args: modes, bank, bank rate, heading, pitch, pitch rate, load, height, climb,
        //       stick roll, stick pitch
        // level flight at 1 g, nothing moves
        row(frame_of(M_NONE, 0, 0, 0, 0, 0, ONE_G, 0, 0, 0, 0), TYPED, 0, 0, 0, ROLL_MANUAL);
        // full stick is 10 degrees on each surface
        row(frame_of(M_NONE, 0, 0, 0, 0, 0, ONE_G, 0, 0, 16384, 16384),
            TYPED, 640, -640, -640, ROLL_MANUAL);
        // rate and load extremes drive every surface into its limit
        row(frame_of(M_NONE, 0, 32767, 0, 0, 32767, 32767, 0, 0, -16384, -16384),
            TYPED, 1920, 1920, 1280, ROLL_MANUAL);
        row(frame_of(M_NONE, 0, -32768, 0, 0, -32768, -32768, 0, 0, 16384, 16384),
            TYPED, -1920, -1920, -1280, ROLL_MANUAL);
        // field extremes beyond the stated ranges
        row(frame_of(M_NONE, 16383, 0, 0, 8191, 0, ONE_G, 524287, 32767, 32767, -32768),
            PREDICTED, 0, 0, 0, ROLL_MANUAL);
        row(frame_of(M_NONE, -16384, 0, 32767, -8192, 0, ONE_G, -524288, -32768, -32768,
                     32767), PREDICTED, 0, 0, 0, ROLL_MANUAL);
        // engage from a steep bank: roll hold on the old bank reference
        row(frame_of(M_ROLL, 0, 0, 0, 0, 0, ONE_G, 0, 0, 0, 0), PREDICTED, 0, 0, 0, ROLL_HOLD);
        // wings level, then engage inside the band: heading hold
        row(frame_of(M_NONE, 0, 0, 0, 0, 0, ONE_G, 0, 0, 0, 0), TYPED, 0, 0, 0, ROLL_MANUAL);
        row(frame_of(M_ROLL, 0, 0, 4480, 0, 0, ONE_G, 0, 0, 0, 0), TYPED, 0, 0, 0, ROLL_HEADING);
        // large heading error: reference saturates, aileron lags by one frame
        row(frame_of(M_ROLL, 0, 0, 0, 0, 0, ONE_G, 0, 0, 0, 0), TYPED, 0, 0, 0, ROLL_HEADING);
        row(frame_of(M_ROLL, 0, 0, 32767, 0, 0, ONE_G, 0, 0, 0, 0),
            PREDICTED, 0, 0, 0, ROLL_HEADING);
        row(frame_of(M_ROLL, 11520, 900, 4480, 0, 0, ONE_G, 0, 0, 0, 0),
            PREDICTED, 0, 0, 0, ROLL_HEADING);
        // capture band edges, both signs
        row(frame_of(M_NONE, 447, 0, 0, 0, 0, ONE_G, 0, 0, 0, 0), PREDICTED, 0, 0, 0, ROLL_MANUAL);
        row(frame_of(M_ROLL, 0, 0, 4000, 0, 0, ONE_G, 0, 0, 0, 0),
            PREDICTED, 0, 0, 0, ROLL_HEADING);
        row(frame_of(M_NONE, -448, 0, 0, 0, 0, ONE_G, 0, 0, 0, 0),
            PREDICTED, 0, 0, 0, ROLL_MANUAL);
        row(frame_of(M_ROLL, 0, 0, 0, 0, 0, ONE_G, 0, 0, 0, 0), PREDICTED, 0, 0, 0, ROLL_HOLD);
        // pitch hold on the pitch seen while it was off
        row(frame_of(M_NONE, 0, 0, 0, 1000, 0, ONE_G, 0, 0, 0, 0),
            PREDICTED, 0, 0, 0, ROLL_MANUAL);
        row(frame_of(M_PITCH, 0, 0, 0, 1000, 0, ONE_G, 0, 0, 0, 0),
            PREDICTED, 0, 0, 0, ROLL_MANUAL);
        row(frame_of(M_PITCH, 0, 0, 0, -5760, 200, ONE_G, 0, 0, 0, 0),
            PREDICTED, 0, 0, 0, ROLL_MANUAL);
        // altitude hold on target, then both reference limits
        row(frame_of(M_ALT, 0, 0, 0, 0, 0, ONE_G, 3200, 0, 0, 0), TYPED, 0, 0, 0, ROLL_MANUAL);
        row(frame_of(M_ALT, 0, 0, 0, 5760, 0, ONE_G, -524288, 0, 0, 0),
            PREDICTED, 0, 0, 0, ROLL_MANUAL);
        row(frame_of(M_ALT, 0, 0, 0, -5760, -700, ONE_G, 524287, 0, 0, 0),
            PREDICTED, 0, 0, 0, ROLL_MANUAL);
        // vertical speed hold at target (offset only), and at its limit
        row(frame_of(M_VS, 0, 0, 0, 0, 0, ONE_G, 0, 128, 0, 0), PREDICTED, 0, 0, 0, ROLL_MANUAL);
        row(frame_of(M_VS, 0, 0, 0, 300, 0, ONE_G, 0, -32768, 0, 0),
            PREDICTED, 0, 0, 0, ROLL_MANUAL);
        // every mode at once, vertical speed wins the elevator
        row(frame_of(M_ROLL | M_PITCH | M_ALT | M_VS, -300, 1200, 9000, 400, -900, 100, 3000,
                     150, 9000, -9000), PREDICTED, 0, 0, 0, ROLL_MANUAL);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_frame(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // random phases, each behind a full register update while idle
        for (p = 0; p < PHASES; p++)
        begin
            if (p < 6)
                program_targets(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                                phase_cfg[p][3]);
            else
                program_targets(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            // one stretch without gaps mid-run, and none at the end
            idle_on = !(p == 4 || p == PHASES - 1);
            repeat (ITEMS_PER_PHASE)
                send_frame(random_frame(), PREDICTED, none);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d frames (%0d directed) in %0d register phases, %0d results checked",
                 frames_sent, dir_rows.size(), PHASES + 1, surfaces_checked);
        $display("roll mode mix: manual %0d, roll hold %0d, heading hold %0d, %0d cycles",
                 mode_hits[0], mode_hits[1], mode_hits[2], cycle_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
